@@ src/motion_sensor_poll_sequencer_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the motion sensor poll sequencer
// Shared forms for the concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef MOTION_SENSOR_POLL_SEQUENCER_CORE_MACROS_SVH
`define MOTION_SENSOR_POLL_SEQUENCER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSPS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/msps_pkg.sv @@
// ---------------------------------------------------------------------------
// Motion sensor poll sequencer package
// Payload types, sequencer phase codes and sensor command bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msps_pkg;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_data;
   } req_type;

   typedef struct packed {
      logic [7:0]         tx_address;
      logic [7:0]         tx_data;
      logic signed [15:0] sum_x;
      logic signed [15:0] sum_y;
      logic               report_request;
   } rsp_type;

   typedef enum logic [5:0] {
      PH_SET_RES  = 6'b000001,
      PH_SET_REST = 6'b000010,
      PH_INIT     = 6'b000100,
      PH_MOTION   = 6'b001000,
      PH_DELTA_Y  = 6'b010000,
      PH_DELTA_X  = 6'b100000
   } phase_type;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_DONE  = 1'b1;

   localparam logic [1:0] CSR_REPORT_ENABLE = 2'd0;
   localparam logic [1:0] CSR_RESOLUTION    = 2'd1;
   localparam logic [1:0] CSR_REST_RATE     = 2'd2;

   localparam logic [7:0] CMD_RESET_ADDR  = 8'hBA;
   localparam logic [7:0] CMD_RESET_DATA  = 8'h5A;
   localparam logic [7:0] CMD_RES_ADDR    = 8'h91;
   localparam logic [7:0] CMD_REST_ADDR   = 8'h18;
   localparam logic [7:0] CMD_MOTION_ADDR = 8'h02;
   localparam logic [7:0] CMD_DY_ADDR     = 8'h03;
   localparam logic [7:0] CMD_DX_ADDR     = 8'h04;
   localparam logic [7:0] CMD_NO_DATA     = 8'h00;

   localparam int MOTION_FLAG_POS = 7;

   localparam logic [7:0] RESOLUTION_RESET = 8'd128;
   localparam logic [7:0] REST_RATE_RESET  = 8'd9;

endpackage

@@ src/motion_sensor_poll_sequencer_core.sv @@
// ---------------------------------------------------------------------------
// Motion sensor poll sequencer
// Picks the next SPI command for an optical motion sensor and keeps the
// swapped-axis motion sums.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  req_     | in        | req_valid / req_ready   | action, rx_data
//  rsp_     | out       | rsp_valid / rsp_ready   | command bytes, sums, report
//  csr_     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
//  Each request yields one response, registered and presented in the cycle after it is accepted.
//  A new request is accepted every cycle while the response register is
//  empty or being drained; the response register is the only stage.
//  A stalled response holds req_ready low. The CSR port is always ready.
//  Reset is synchronous and puts the phase at the resolution write, the
//  sums at zero and the registers at their defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "motion_sensor_poll_sequencer_core_macros.svh"

module motion_sensor_poll_sequencer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  msps_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msps_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);
   import msps_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] accum_x_ff, accum_x_in;
   logic [15:0] accum_y_ff, accum_y_in;
   logic        report_enable_ff;
   logic [7:0]  resolution_ff;
   logic [7:0]  rest_rate_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_payload_ff, rsp_payload_in;
   logic        req_fire;
   logic [15:0] rx_ext;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rx_ext      = {{8{req_payload.rx_data[7]}}, req_payload.rx_data};

   always_comb begin
      phase_in   = phase_ff;
      accum_x_in = accum_x_ff;
      accum_y_in = accum_y_ff;
      rsp_payload_in.tx_data        = CMD_NO_DATA;
      rsp_payload_in.report_request = 1'b0;
      rsp_payload_in.tx_address     = CMD_MOTION_ADDR;

      if (req_payload.action == ACT_START) begin
         rsp_payload_in.tx_address = CMD_RESET_ADDR;
         rsp_payload_in.tx_data    = CMD_RESET_DATA;
         phase_in                  = PH_SET_RES;
      end else begin
         case (phase_ff)
            PH_SET_REST: begin
               rsp_payload_in.tx_address = CMD_REST_ADDR;
               rsp_payload_in.tx_data    = rest_rate_ff;
               phase_in                  = PH_INIT;
            end
            PH_INIT: begin
               phase_in = PH_MOTION;
            end
            PH_MOTION: begin
               // With the motion bit clear the motion register is polled again.
               if (req_payload.rx_data[MOTION_FLAG_POS]) begin
                  rsp_payload_in.tx_address = CMD_DY_ADDR;
                  phase_in                  = PH_DELTA_Y;
               end
            end
            PH_DELTA_Y: begin
               // Axes are swapped: delta Y lands in the X sum.
               accum_x_in                = accum_x_ff + rx_ext;
               rsp_payload_in.tx_address = CMD_DX_ADDR;
               phase_in                  = PH_DELTA_X;
            end
            PH_DELTA_X: begin
               accum_y_in                    = accum_y_ff + rx_ext;
               phase_in                      = PH_MOTION;
               rsp_payload_in.report_request = report_enable_ff;
            end
            default: begin
               rsp_payload_in.tx_address = CMD_RES_ADDR;
               rsp_payload_in.tx_data    = resolution_ff;
               phase_in                  = PH_SET_REST;
            end
         endcase
      end

      rsp_payload_in.sum_x = accum_x_in;
      rsp_payload_in.sum_y = accum_y_in;
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SET_RES;
         accum_x_ff       <= '0;
         accum_y_ff       <= '0;
         report_enable_ff <= 1'b0;
         resolution_ff    <= RESOLUTION_RESET;
         rest_rate_ff     <= REST_RATE_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff   <= phase_in;
            accum_x_ff <= accum_x_in;
            accum_y_ff <= accum_y_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REPORT_ENABLE: report_enable_ff <= csr_data[0];
               CSR_RESOLUTION:    resolution_ff    <= csr_data;
               CSR_REST_RATE:     rest_rate_ff     <= csr_data;
               default:           ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   `MSPS_ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready, "request taken while response stalled")
   `MSPS_ASSERT_NEXT(a_start_resets_phase, clock, reset, req_fire && req_payload.action == ACT_START, phase_ff == PH_SET_RES && rsp_payload_ff.tx_address == CMD_RESET_ADDR, "start did not restart sequence")
   `MSPS_ASSERT_NEXT(a_sum_x_hold, clock, reset, !(req_fire && req_payload.action == ACT_DONE && phase_ff == PH_DELTA_Y), $stable(accum_x_ff), "X sum changed outside delta Y read")
   `MSPS_ASSERT_SAME(a_report_with_poll, clock, reset, rsp_valid_ff && rsp_payload_ff.report_request, rsp_payload_ff.tx_address == CMD_MOTION_ADDR && phase_ff == PH_MOTION, "report raised off the delta pair end")
   `MSPS_ASSERT_SAME(a_phase_onehot, clock, reset, 1'b1, $onehot(phase_ff), "phase lost one-hot encoding")

endmodule

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// Motion sensor poll sequencer testbench
// Drives start and transfer-done requests through the sequencer. A local
// model of the command sequence and the swapped-axis sums predicts every
// response, which is compared field by field. Directed tests cover startup
// without a start request, delta extremes, restarts in the middle of a read
// sequence and register extremes. Random phases then let both sums drift far
// enough to wrap. Both channels see random gaps and stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import msps_pkg::*;

   localparam int CYCLE_LIMIT = 500_000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_REPORT_ENABLE;
   logic [7:0] csr_data = 8'h00;

   // Model of the sequencer: configuration copy, phase and sums.
   logic        report_enable_cfg = 1'b0;
   logic [7:0]  resolution_cfg = RESOLUTION_RESET;
   logic [7:0]  rest_rate_cfg = REST_RATE_RESET;
   phase_type   seq_phase = PH_SET_RES;
   logic [15:0] sum_x_model = '0;
   logic [15:0] sum_y_model = '0;

   rsp_type pending_commands[$];

   int  fail_count = 0;
   int  request_count = 0;
   int  response_count = 0;
   int  delta_pairs = 0;
   int  report_count = 0;
   int  wrap_count = 0;
   int  start_count = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  source_gaps = 1'b0;
   bit  sink_stalls = 1'b0;

   motion_sensor_poll_sequencer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] accumulate(logic [15:0] sum, logic [7:0] delta);
      logic [15:0] wide_delta;
      logic [15:0] result;
      wide_delta = {{8{delta[7]}}, delta};
      result = sum + wide_delta;
      if (sum[15] == wide_delta[15] && result[15] != sum[15]) begin
         wrap_count++;
      end
      return result;
   endfunction

   // Next command and sums after one accepted request.
   function automatic rsp_type next_command(req_type item);
      rsp_type cmd;
      cmd = '0;
      cmd.tx_data = CMD_NO_DATA;
      if (item.action == ACT_START) begin
         cmd.tx_address = CMD_RESET_ADDR;
         cmd.tx_data = CMD_RESET_DATA;
         seq_phase = PH_SET_RES;
         start_count++;
      end else begin
         case (seq_phase)
            PH_SET_REST: begin
               cmd.tx_address = CMD_REST_ADDR;
               cmd.tx_data = rest_rate_cfg;
               seq_phase = PH_INIT;
            end
            PH_INIT: begin
               cmd.tx_address = CMD_MOTION_ADDR;
               seq_phase = PH_MOTION;
            end
            PH_MOTION: begin
               if (item.rx_data[MOTION_FLAG_POS]) begin
                  cmd.tx_address = CMD_DY_ADDR;
                  seq_phase = PH_DELTA_Y;
               end else begin
                  cmd.tx_address = CMD_MOTION_ADDR;
               end
            end
            PH_DELTA_Y: begin
               // Delta Y feeds the X sum.
               sum_x_model = accumulate(sum_x_model, item.rx_data);
               cmd.tx_address = CMD_DX_ADDR;
               seq_phase = PH_DELTA_X;
            end
            PH_DELTA_X: begin
               sum_y_model = accumulate(sum_y_model, item.rx_data);
               cmd.tx_address = CMD_MOTION_ADDR;
               cmd.report_request = report_enable_cfg;
               seq_phase = PH_MOTION;
               delta_pairs++;
            end
            default: begin
               cmd.tx_address = CMD_RES_ADDR;
               cmd.tx_data = resolution_cfg;
               seq_phase = PH_SET_REST;
            end
         endcase
      end
      cmd.sum_x = sum_x_model;
      cmd.sum_y = sum_y_model;
      return cmd;
   endfunction

   task automatic send_request(input logic action, input logic [7:0] rx);
      req_type item;
      int gap;
      item.action = action;
      item.rx_data = rx;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      pending_commands.push_back(next_command(item));
      request_count++;
      if (source_gaps && $urandom_range(0, 99) < 30) begin
         gap = pick_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The sender holds off until every outstanding response has come back.
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_REPORT_ENABLE: report_enable_cfg = value[0];
         CSR_RESOLUTION:    resolution_cfg = value;
         CSR_REST_RATE:     rest_rate_cfg = value;
         default: ;
      endcase
   endtask

   task automatic write_registers(input logic report, input logic [7:0] resolution,
                                  input logic [7:0] rest_rate);
      wait_all_responses();
      csr_write(CSR_REPORT_ENABLE, {7'd0, report});
      csr_write(CSR_RESOLUTION, resolution);
      csr_write(CSR_REST_RATE, rest_rate);
      csr_valid <= 1'b0;
   endtask

   // Completions straight after reset run the sequence from the reset phase
   // with the default register values; bytes outside the read phases are ignored.
   task automatic test_no_start_after_reset();
      send_request(ACT_DONE, 8'hFF);
      send_request(ACT_DONE, 8'h00);
      send_request(ACT_DONE, 8'h80);
      send_request(ACT_DONE, 8'h7F);
   endtask

   task automatic test_delta_extremes();
      write_registers(1'b1, 8'hFF, 8'h00);
      source_gaps = 1'b1;
      send_request(ACT_START, 8'h00);
      send_request(ACT_DONE, 8'hFF);
      send_request(ACT_DONE, 8'hAA);
      send_request(ACT_DONE, 8'h55);
      send_request(ACT_DONE, 8'h80);
      send_request(ACT_DONE, 8'h7F);
      send_request(ACT_DONE, 8'h80);
      send_request(ACT_DONE, 8'hFF);
      send_request(ACT_DONE, 8'h00);
      send_request(ACT_DONE, 8'hFF);
   endtask

   // A start in the middle of a read sequence restarts it but keeps the sums.
   task automatic test_start_midsequence();
      write_registers(1'b0, 8'h00, 8'hFF);
      sink_stalls = 1'b1;
      send_request(ACT_DONE, 8'h80);
      send_request(ACT_START, 8'h3C);
      send_request(ACT_DONE, 8'h80);
      send_request(ACT_DONE, 8'h01);
      send_request(ACT_DONE, 8'hFE);
      send_request(ACT_DONE, 8'hC0);
      send_request(ACT_DONE, 8'h01);
      send_request(ACT_START, 8'hFF);
   endtask

   // Random requests; drift > 0 or < 0 biases deltas to push both sums one way.
   task automatic run_random_phase(input int count, input int drift, input int motion_pct);
      logic       action;
      logic [7:0] rx;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            source_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
         end
         action = ($urandom_range(0, 99) < 2) ? ACT_START : ACT_DONE;
         rx = 8'($urandom_range(0, 255));
         case (seq_phase)
            PH_MOTION: rx[MOTION_FLAG_POS] = ($urandom_range(0, 99) < motion_pct);
            PH_DELTA_Y, PH_DELTA_X: begin
               if (drift > 0 && $urandom_range(0, 99) < 97) begin
                  rx = 8'($urandom_range(8'h78, 8'h7F));
               end else if (drift < 0 && $urandom_range(0, 99) < 97) begin
                  rx = 8'($urandom_range(8'h80, 8'h87));
               end
            end
            default: ;
         endcase
         send_request(action, rx);
      end
   endtask

   task automatic test_random();
      write_registers(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random_phase(250, 0, 50);
      write_registers(1'b0, 8'd128, 8'd9);
      run_random_phase(500, 1, 100);
      write_registers(1'b1, 8'h00, 8'h00);
      run_random_phase(500, 1, 95);
      write_registers(1'b1, 8'hFF, 8'hFF);
      run_random_phase(300, -1, 90);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (sink_stalls && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_gap();
         end
      end
   end

   function automatic void compare_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (pending_commands.size() == 0) begin
            $error("response with no request outstanding: tx_address %0d",
                   rsp_payload.tx_address);
            fail_count++;
         end else begin
            expected = pending_commands.pop_front();
            compare_field("tx_address", expected.tx_address, rsp_payload.tx_address);
            compare_field("tx_data", expected.tx_data, rsp_payload.tx_data);
            compare_field("sum_x", int'(expected.sum_x), int'(rsp_payload.sum_x));
            compare_field("sum_y", int'(expected.sum_y), int'(rsp_payload.sum_y));
            compare_field("report_request", expected.report_request,
                          rsp_payload.report_request);
            if (rsp_payload.report_request) begin
               report_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_no_start_after_reset();
      test_delta_extremes();
      test_start_midsequence();
      test_random();
      wait_all_responses();
      repeat (5) @(posedge clock);
      if (pending_commands.size() != 0) begin
         $error("%0d responses never arrived", pending_commands.size());
         fail_count++;
      end
      $display("Sent %0d requests (%0d starts), checked %0d responses in %0d cycles.",
               request_count, start_count, response_count, cycle_count);
      $display("Saw %0d delta pairs, %0d report requests and %0d sum wraps.",
               delta_pairs, report_count, wrap_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/msps_pkg.sv
src/motion_sensor_poll_sequencer_core.sv
dv/testbench.sv
